// ===== design/i2c_slave_register_file_core_assert.svh =====
// ----------------------------------------------------------------------------
// i2c_slave_register_file_core assertion macros
// Immediate-implication and next-cycle-implication checks on clk_i / rst_ni.
// ----------------------------------------------------------------------------
`ifndef I2C_SLAVE_REGISTER_FILE_CORE_ASSERT_SVH
`define I2C_SLAVE_REGISTER_FILE_CORE_ASSERT_SVH

// antecedent holds -> consequent holds in the same cycle
`define I2CSRF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("i2csrf: same-cycle check failed");

// antecedent holds -> consequent holds in the next cycle
`define I2CSRF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("i2csrf: next-cycle check failed");

`endif

// ===== design/i2csrf_pkg.sv =====
// ----------------------------------------------------------------------------
// i2csrf_pkg
// Shared constants and types of the I2C target register file.
// ----------------------------------------------------------------------------
`default_nettype none

package i2csrf_pkg;

  localparam int unsigned MapDepthDefault    = 256;
  localparam int unsigned StatusBytesDefault = 4;

  // bus / device events
  typedef enum logic [2:0] {
    OP_READ_BYTE  = 3'd0,
    OP_READ_NACK  = 3'd1,
    OP_ADDR_WRITE = 3'd2,
    OP_DATA_RECV  = 3'd3,
    OP_STOP       = 3'd4,
    OP_ERROR      = 3'd5,
    OP_LOCAL_WR   = 3'd6,
    OP_UNKNOWN    = 3'd7
  } op_e;

  // configuration register indexes
  localparam logic [1:0] CfgLastReadable  = 2'd0;
  localparam logic [1:0] CfgFirstWritable = 2'd1;
  localparam logic [1:0] CfgFirstStatus   = 2'd2;

  localparam logic [7:0] LastReadableReset  = 8'd63;
  localparam logic [7:0] FirstWritableReset = 8'd0;
  localparam logic [7:0] FirstStatusReset   = 8'd0;

endpackage

`default_nettype wire

// ===== design/i2csrf_ram.sv =====
// ----------------------------------------------------------------------------
// i2csrf_ram
// Generic single-write, single-read RAM with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module i2csrf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== design/i2c_slave_register_file_core.sv =====
// ----------------------------------------------------------------------------
// i2c_slave_register_file_core
// Byte-level I2C target register map driven by decoded bus events.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one bus or device event a
//   transaction: op_i, data_in_i, local_addr_i, bus_code_i. Every event yields
//   exactly one result transaction on the output channel (out_valid_o /
//   out_stall_i): read_data_o, busy_res_o, change_release_o, bus_release_o,
//   error_code_o.
//   Non-read events, and reads past last_readable, finish at the accepting
//   edge: result is valid the next cycle, one event per cycle sustained
//   while the output is not stalled. A read inside the readable range
//   fetches the map byte (S_RD), walks the STATUS_BYTES shadow slots through
//   the map RAM read port (S_CHK, one slot per cycle, pipelined) and loads
//   the result from S_DONE once the output is free; no new event is taken
//   until the block is back in S_IDLE.
//   Configuration (cfg_valid_i / cfg_ready_o, cfg_index_i, cfg_data_i) is
//   always ready; indexes past the register list are dropped.
//   Reset: map reads as zero via per-entry valid flops, no clearing pass;
//   pointer, flags, shadows and latched error clear at once.
//   A stalled result holds; the block stops taking events until it drains.
// ----------------------------------------------------------------------------
`default_nettype none

`include "i2c_slave_register_file_core_assert.svh"

module i2c_slave_register_file_core #(
  parameter int unsigned MAP_DEPTH    = i2csrf_pkg::MapDepthDefault,
  parameter int unsigned STATUS_BYTES = i2csrf_pkg::StatusBytesDefault
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // event channel
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [2:0] op_i,
  input  wire logic [7:0] data_in_i,
  input  wire logic [7:0] local_addr_i,
  input  wire logic [7:0] bus_code_i,
  // result channel
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic      [7:0] read_data_o,
  output logic            busy_res_o,
  output logic            change_release_o,
  output logic            bus_release_o,
  output logic      [7:0] error_code_o,
  // configuration write channel
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic [7:0] cfg_data_i
);

  import i2csrf_pkg::*;

  localparam int unsigned AW = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
  localparam int unsigned SW = (STATUS_BYTES > 1) ? $clog2(STATUS_BYTES) : 1;
  localparam int unsigned CW = $clog2(STATUS_BYTES + 1);

  localparam logic [8:0]    MapLimit = 9'(MAP_DEPTH);
  localparam logic [7:0]    StatLim  = 8'(STATUS_BYTES);
  localparam logic [CW-1:0] CntLast  = CW'(STATUS_BYTES);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;  // take events
  localparam logic [1:0] S_RD   = 2'd1;  // map byte returning
  localparam logic [1:0] S_CHK  = 2'd2;  // shadow match walk
  localparam logic [1:0] S_DONE = 2'd3;  // read result waiting for output

  logic [1:0] state_q, state_d;

  // configuration
  logic [7:0] last_rd_q, first_wr_q, first_st_q;

  // architectural state
  logic [7:0]           ptr_q, ptr_d;
  logic                 writing_q, writing_d;
  logic                 busy_q, busy_d;
  logic [7:0]           err_q, err_d;
  logic [7:0]           shadow_q [STATUS_BYTES];
  logic [MAP_DEPTH-1:0] map_vld_q;

  // read sequencing
  logic [7:0]    rd_ptr_q, rd_ptr_d;
  logic          rd_ok_q, rd_ok_d;    // fetched map entry is real (in map, written)
  logic [7:0]    rd_data_q, rd_data_d;
  logic          chk_ok_q, chk_ok_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          mism_q, mism_d;
  logic          chg_q, chg_d;

  // output register
  logic       out_valid_q;
  logic [7:0] out_rd_q, out_err_q;
  logic       out_busy_q, out_chg_q, out_rel_q;

  // RAM port
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  // combinational helpers
  logic          in_acc, out_free, out_load;
  logic [7:0]    ld_rd, ld_err;
  logic          ld_busy, ld_chg, ld_rel;
  logic          shd_we, shd_clr;
  logic [SW-1:0] shd_idx, cmp_idx;
  logic [7:0]    rd_byte, cur_byte, chk_addr, rd_off;
  logic          miss;

  i2csrf_ram #(
    .Width(8),
    .Depth(MAP_DEPTH),
    .AddrW(AW)
  ) u_map_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // byte returned for the pointer read, and its status slot offset
  assign rd_byte = rd_ok_q ? ram_rdata : 8'd0;
  assign rd_off  = rd_ptr_q - first_st_q;
  assign shd_idx = rd_off[SW-1:0];

  // walk: slot cnt-1 compares while slot cnt is fetched
  assign cur_byte = chk_ok_q ? ram_rdata : 8'd0;
  assign cmp_idx  = SW'(cnt_q - CW'(1));
  assign miss     = (cur_byte != shadow_q[cmp_idx]);

  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    writing_d = writing_q;
    busy_d    = busy_q;
    err_d     = err_q;
    rd_ptr_d  = rd_ptr_q;
    rd_ok_d   = rd_ok_q;
    rd_data_d = rd_data_q;
    chk_ok_d  = chk_ok_q;
    cnt_d     = cnt_q;
    mism_d    = mism_q;
    chg_d     = chg_q;
    ram_we    = 1'b0;
    ram_waddr = ptr_q[AW-1:0];
    ram_wdata = data_in_i;
    ram_raddr = ptr_q[AW-1:0];
    shd_we    = 1'b0;
    shd_clr   = 1'b0;
    out_load  = 1'b0;
    ld_rd     = 8'd0;
    ld_chg    = 1'b0;
    ld_rel    = 1'b0;
    ld_busy   = busy_q;
    ld_err    = err_q;
    chk_addr  = first_st_q + 8'(cnt_q);

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          out_load = 1'b1;
          unique case (op_e'(op_i))
            OP_READ_BYTE: begin
              writing_d = 1'b0;
              busy_d    = 1'b1;
              ptr_d     = ptr_q + 8'd1;
              if (ptr_q <= last_rd_q) begin
                // in range: result comes after fetch and match walk
                out_load  = 1'b0;
                rd_ptr_d  = ptr_q;
                rd_ok_d   = ({1'b0, ptr_q} < MapLimit) && map_vld_q[ptr_q[AW-1:0]];
                state_d   = S_RD;
              end
            end
            OP_READ_NACK, OP_STOP: begin
              busy_d = 1'b0;
            end
            OP_ADDR_WRITE: begin
              busy_d    = 1'b1;
              writing_d = 1'b0;
            end
            OP_DATA_RECV: begin
              if (writing_q) begin
                ram_we = (ptr_q >= first_wr_q) && (ptr_q <= last_rd_q)
                         && ({1'b0, ptr_q} < MapLimit);
                ptr_d  = ptr_q + 8'd1;
              end else begin
                ptr_d = data_in_i;
              end
              writing_d = 1'b1;
              busy_d    = 1'b1;
            end
            OP_ERROR: begin
              err_d  = bus_code_i;
              ld_rel = 1'b1;
            end
            OP_LOCAL_WR: begin
              ram_waddr = local_addr_i[AW-1:0];
              ram_we    = ({1'b0, local_addr_i} < MapLimit);
            end
            OP_UNKNOWN: begin
              err_d  = bus_code_i;
              busy_d = 1'b0;
            end
            default: begin
              err_d = err_q;
            end
          endcase
          ld_busy = busy_d;
          ld_err  = err_d;
        end
      end
      S_RD: begin
        rd_data_d = rd_byte;
        shd_we    = (rd_off < StatLim);
        chk_addr  = first_st_q;
        ram_raddr = chk_addr[AW-1:0];
        chk_ok_d  = ({1'b0, chk_addr} < MapLimit) && map_vld_q[chk_addr[AW-1:0]];
        cnt_d     = CW'(1);
        mism_d    = 1'b0;
        state_d   = S_CHK;
      end
      S_CHK: begin
        if (cnt_q < CntLast) begin
          ram_raddr = chk_addr[AW-1:0];
          chk_ok_d  = ({1'b0, chk_addr} < MapLimit) && map_vld_q[chk_addr[AW-1:0]];
          cnt_d     = cnt_q + CW'(1);
          mism_d    = mism_q || miss;
        end else begin
          chg_d   = !(mism_q || miss);
          shd_clr = !(mism_q || miss);
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_load = 1'b1;
          ld_rd    = rd_data_q;
          ld_chg   = chg_q;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ptr_q       <= 8'd0;
      writing_q   <= 1'b0;
      busy_q      <= 1'b0;
      err_q       <= 8'd0;
      map_vld_q   <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      last_rd_q   <= LastReadableReset;
      first_wr_q  <= FirstWritableReset;
      first_st_q  <= FirstStatusReset;
      for (int i = 0; i < int'(STATUS_BYTES); i++) begin
        shadow_q[i] <= 8'd0;
      end
    end else begin
      state_q   <= state_d;
      ptr_q     <= ptr_d;
      writing_q <= writing_d;
      busy_q    <= busy_d;
      err_q     <= err_d;
      cnt_q     <= cnt_d;
      if (ram_we) begin
        map_vld_q[ram_waddr] <= 1'b1;
      end
      if (shd_clr) begin
        for (int i = 0; i < int'(STATUS_BYTES); i++) begin
          shadow_q[i] <= 8'd0;
        end
      end else if (shd_we) begin
        shadow_q[shd_idx] <= rd_byte;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CfgLastReadable:  last_rd_q  <= cfg_data_i;
          CfgFirstWritable: first_wr_q <= cfg_data_i;
          CfgFirstStatus:   first_st_q <= cfg_data_i;
          default: begin
            last_rd_q <= last_rd_q;
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rd_ptr_q  <= rd_ptr_d;
    rd_ok_q   <= rd_ok_d;
    rd_data_q <= rd_data_d;
    chk_ok_q  <= chk_ok_d;
    mism_q    <= mism_d;
    chg_q     <= chg_d;
    if (out_load) begin
      out_rd_q   <= ld_rd;
      out_busy_q <= ld_busy;
      out_chg_q  <= ld_chg;
      out_rel_q  <= ld_rel;
      out_err_q  <= ld_err;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign read_data_o      = out_rd_q;
  assign busy_res_o       = out_busy_q;
  assign change_release_o = out_chg_q;
  assign bus_release_o    = out_rel_q;
  assign error_code_o     = out_err_q;

  // a release pulse only comes from an in-range read, which sets busy
  `I2CSRF_ASSERT_IMP(a_chg_busy, out_valid_q && out_chg_q, out_busy_q)
  // error results carry no read byte and no release pulse
  `I2CSRF_ASSERT_IMP(a_rel_clean, out_valid_q && out_rel_q, (out_rd_q == 8'd0) && !out_chg_q)
  // walk counter stays within the shadow slots
  `I2CSRF_ASSERT_IMP(a_cnt_range, state_q == S_CHK, (cnt_q != '0) && (cnt_q <= CntLast))
  // map writes never overlap a read sequence
  `I2CSRF_ASSERT_IMP(a_we_idle, ram_we, state_q == S_IDLE)

endmodule

`default_nettype wire

// ===== tb/sv/i2c_slave_register_file_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_slave_register_file_core_tb
// Self-checking bench for the I2C target register file. Bus and device events
// go in on a valid/stall channel. Every event returns one result transaction,
// which is checked in order against a cycle-free predictor of the map,
// pointer, flags, status shadows and latched error. A directed table comes
// first. Then random, mostly well-formed bus transfers run under several
// window settings, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module i2c_slave_register_file_core_tb;
  import i2csrf_pkg::*;

  localparam int unsigned MapDepth      = MapDepthDefault;
  localparam int unsigned StatusBytes   = StatusBytesDefault;
  localparam int unsigned NumPhases     = 8;
  localparam int unsigned ItemsPerPhase = 235;
  localparam int unsigned TailCycles    = 20;
  localparam int unsigned MaxGap        = 12;
  // index past the register list: the block must drop it
  localparam logic [1:0]  CfgSpare      = 2'd3;

  typedef struct packed {
    logic [7:0] read_data;
    logic       busy;
    logic       chg_release;
    logic       bus_release;
    logic [7:0] err_code;
  } result_t;

  typedef struct {
    op_e        op;
    logic [7:0] din;
    logic [7:0] laddr;
    logic [7:0] code;
    bit         typed;  // expected result written out below
    result_t    res;
  } ev_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i;
  logic       in_stall_o;
  op_e        op_i;
  logic [7:0] data_in_i;
  logic [7:0] local_addr_i;
  logic [7:0] bus_code_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] read_data_o;
  logic       busy_res_o;
  logic       change_release_o;
  logic       bus_release_o;
  logic [7:0] error_code_o;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [1:0] cfg_index_i;
  logic [7:0] cfg_data_i;

  i2c_slave_register_file_core u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .op_i             (op_i),
    .data_in_i        (data_in_i),
    .local_addr_i     (local_addr_i),
    .bus_code_i       (bus_code_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .read_data_o      (read_data_o),
    .busy_res_o       (busy_res_o),
    .change_release_o (change_release_o),
    .bus_release_o    (bus_release_o),
    .error_code_o     (error_code_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor state: our own copy of the map, the bus pointer, the flags,
  // the status shadows and the window registers.
  // --------------------------------------------------------------------------
  logic [7:0] map_mem [MapDepth];
  logic [7:0] shadow_mem [StatusBytes];
  logic [7:0] bus_ptr;
  logic       wr_flag;
  logic       busy_flag;
  logic [7:0] err_latched;
  logic [7:0] cfg_last_rd;
  logic [7:0] cfg_first_wr;
  logic [7:0] cfg_first_st;

  result_t     awaited_results [$];
  int unsigned n_mismatch  = 0;
  int unsigned events_sent = 0;
  int unsigned src_gap_max = MaxGap;
  int unsigned snk_gap_max = MaxGap;
  int unsigned stall_left  = 0;

  // Map port with the beyond-depth rule: reads give 0, writes are dropped.
  function automatic logic [7:0] map_rd(input logic [7:0] a);
    return (32'(a) < MapDepth) ? map_mem[a] : 8'h00;
  endfunction

  function automatic void map_wr(input logic [7:0] a, input logic [7:0] v);
    if (32'(a) < MapDepth) map_mem[a] = v;
  endfunction

  // Works out the result of one accepted event and moves the state on.
  function automatic result_t apply_bus_event(input op_e op, input logic [7:0] din,
                                              input logic [7:0] laddr,
                                              input logic [7:0] code);
    result_t    r;
    logic [7:0] off;
    logic [7:0] a;
    logic       all_eq;
    r = '0;
    case (op)
      OP_READ_BYTE: begin
        if (bus_ptr <= cfg_last_rd) begin
          off = bus_ptr - cfg_first_st;
          r.read_data = map_rd(bus_ptr);
          if (32'(off) < StatusBytes) shadow_mem[off] = r.read_data;
          // match check only runs on an in-range read
          all_eq = 1'b1;
          for (int i = 0; i < int'(StatusBytes); i++) begin
            a = cfg_first_st + 8'(i);
            if (shadow_mem[i] != map_rd(a)) all_eq = 1'b0;
          end
          if (all_eq) begin
            r.chg_release = 1'b1;
            foreach (shadow_mem[i]) shadow_mem[i] = 8'h00;
          end
        end
        bus_ptr   = bus_ptr + 8'd1;
        wr_flag   = 1'b0;
        busy_flag = 1'b1;
      end
      OP_READ_NACK, OP_STOP: busy_flag = 1'b0;
      OP_ADDR_WRITE: begin
        busy_flag = 1'b1;
        wr_flag   = 1'b0;
      end
      OP_DATA_RECV: begin
        if (wr_flag) begin
          if (bus_ptr >= cfg_first_wr && bus_ptr <= cfg_last_rd) map_wr(bus_ptr, din);
          bus_ptr = bus_ptr + 8'd1;
        end else begin
          bus_ptr = din;  // first byte after address is the pointer
        end
        wr_flag   = 1'b1;
        busy_flag = 1'b1;
      end
      OP_ERROR: begin
        err_latched   = code;
        r.bus_release = 1'b1;
      end
      OP_LOCAL_WR: map_wr(laddr, din);
      default: begin
        err_latched = code;
        busy_flag   = 1'b0;
      end
    endcase
    r.busy     = busy_flag;
    r.err_code = err_latched;
    return r;
  endfunction

  // Addresses clustered on the window edges, where the behaviour turns.
  function automatic logic [7:0] pick_addr();
    case ($urandom_range(0, 3))
      0:       return cfg_first_st + 8'($urandom_range(0, 5)) - 8'd1;
      1:       return cfg_last_rd + 8'($urandom_range(0, 3)) - 8'd2;
      2:       return cfg_first_wr + 8'($urandom_range(0, 2)) - 8'd1;
      default: return 8'($urandom);
    endcase
  endfunction

  // Zero-heavy bytes so that status reads match the map now and then.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0, 1:    return 8'h00;
      2:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void note_mismatch(input string what, input result_t want,
                                        input result_t got);
    n_mismatch++;
    if (n_mismatch <= 10)
      $display("%0t: %s: exp rd=%h busy=%b chg=%b rel=%b err=%h, got rd=%h busy=%b chg=%b rel=%b err=%h",
               $realtime, what, want.read_data, want.busy, want.chg_release,
               want.bus_release, want.err_code, got.read_data, got.busy, got.chg_release,
               got.bus_release, got.err_code);
  endfunction

  // --------------------------------------------------------------------------
  // Event sender. Entered and left at a falling edge. A zero gap keeps valid
  // high so transactions run back to back; otherwise valid drops for the gap.
  // The expectation is queued at the accepting edge.
  // --------------------------------------------------------------------------
  task automatic send_event(input op_e op, input logic [7:0] din, input logic [7:0] laddr,
                            input logic [7:0] code, input bit typed = 1'b0,
                            input result_t typed_res = '0);
    int unsigned gap;
    result_t     pred;
    gap = $urandom_range(0, src_gap_max);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    op_i         <= op;
    data_in_i    <= din;
    local_addr_i <= laddr;
    bus_code_i   <= code;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pred = apply_bus_event(op, din, laddr, code);
    awaited_results.push_back(typed ? typed_res : pred);
    events_sent++;
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every queued result has come back. Every event
  // gives a result, so the block is idle once the queue is empty.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Writes all three window registers plus the spare index, which must be
  // ignored. Entered and left at a falling edge, valid dropped once at the end.
  task automatic write_windows(input logic [7:0] lr, input logic [7:0] fw,
                               input logic [7:0] fs);
    logic [1:0] idx [4];
    logic [7:0] val [4];
    idx = '{CfgLastReadable, CfgFirstWritable, CfgFirstStatus, CfgSpare};
    val = '{lr, fw, fs, 8'($urandom)};
    for (int k = 0; k < 4; k++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[k];
      cfg_data_i  <= val[k];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      case (idx[k])
        CfgLastReadable:  cfg_last_rd  = val[k];
        CfgFirstWritable: cfg_first_wr = val[k];
        CfgFirstStatus:   cfg_first_st = val[k];
        default: ;
      endcase
      @(negedge clk_i);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Result side: stall drawn per result, checked in order at the rising edge.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin : rsp_check
    result_t got;
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {read_data_o, busy_res_o, change_release_o, bus_release_o, error_code_o};
      if (awaited_results.size() == 0) begin
        note_mismatch("result with nothing awaited", '0, got);
      end else begin
        want = awaited_results.pop_front();
        if (got.read_data !== want.read_data || got.busy !== want.busy ||
            got.chg_release !== want.chg_release ||
            got.bus_release !== want.bus_release || got.err_code !== want.err_code)
          note_mismatch("result mismatch", want, got);
      end
      stall_left = $urandom_range(0, snk_gap_max);
    end
  end

  // --------------------------------------------------------------------------
  // Directed table, run with reset windows (last readable 63, first writable
  // 0, first status 0). Typed results cover the match at reset, error and
  // unknown-status latching, the field extremes, the write window edge and a
  // read past last_readable. The remaining rows go to the predictor.
  // --------------------------------------------------------------------------
  ev_row_t directed_rows [25] = '{
    // first read: map and shadows both zero, so the match fires
    '{OP_READ_BYTE,  8'h00, 8'h00, 8'h00, 1'b1, {8'h00, 1'b1, 1'b1, 1'b0, 8'h00}},
    '{OP_ERROR,      8'h00, 8'h00, 8'hFF, 1'b1, {8'h00, 1'b1, 1'b0, 1'b1, 8'hFF}},
    '{OP_UNKNOWN,    8'h00, 8'h00, 8'h00, 1'b1, {8'h00, 1'b0, 1'b0, 1'b0, 8'h00}},
    '{OP_ERROR,      8'h00, 8'h00, 8'h5A, 1'b1, {8'h00, 1'b0, 1'b0, 1'b1, 8'h5A}},
    '{OP_LOCAL_WR,   8'hFF, 8'hFF, 8'h00, 1'b1, {8'h00, 1'b0, 1'b0, 1'b0, 8'h5A}},
    '{OP_LOCAL_WR,   8'hA5, 8'h01, 8'h00, 1'b1, {8'h00, 1'b0, 1'b0, 1'b0, 8'h5A}},
    // write at the top of the window, then one past it (dropped)
    '{OP_ADDR_WRITE, 8'h00, 8'h00, 8'h00, 1'b1, {8'h00, 1'b1, 1'b0, 1'b0, 8'h5A}},
    '{OP_DATA_RECV,  8'h3F, 8'h00, 8'h00, 1'b1, {8'h00, 1'b1, 1'b0, 1'b0, 8'h5A}},
    '{OP_DATA_RECV,  8'hFF, 8'h00, 8'h00, 1'b1, {8'h00, 1'b1, 1'b0, 1'b0, 8'h5A}},
    '{OP_DATA_RECV,  8'h00, 8'h00, 8'h00, 1'b1, {8'h00, 1'b1, 1'b0, 1'b0, 8'h5A}},
    '{OP_STOP,       8'h00, 8'h00, 8'h00, 1'b1, {8'h00, 1'b0, 1'b0, 1'b0, 8'h5A}},
    // read back the last readable byte, then read past it
    '{OP_ADDR_WRITE, 8'h00, 8'h00, 8'h00, 1'b1, {8'h00, 1'b1, 1'b0, 1'b0, 8'h5A}},
    '{OP_DATA_RECV,  8'h3F, 8'h00, 8'h00, 1'b1, {8'h00, 1'b1, 1'b0, 1'b0, 8'h5A}},
    '{OP_STOP,       8'h00, 8'h00, 8'h00, 1'b1, {8'h00, 1'b0, 1'b0, 1'b0, 8'h5A}},
    '{OP_READ_BYTE,  8'h00, 8'h00, 8'h00, 1'b1, {8'hFF, 1'b1, 1'b0, 1'b0, 8'h5A}},
    '{OP_READ_BYTE,  8'h00, 8'h00, 8'h00, 1'b1, {8'h00, 1'b1, 1'b0, 1'b0, 8'h5A}},
    '{OP_READ_NACK,  8'h00, 8'h00, 8'h00, 1'b1, {8'h00, 1'b0, 1'b0, 1'b0, 8'h5A}},
    // data without an address event still loads the pointer
    '{OP_DATA_RECV,  8'h00, 8'h00, 8'h00, 1'b1, {8'h00, 1'b1, 1'b0, 1'b0, 8'h5A}},
    '{OP_STOP,       8'h00, 8'h00, 8'h00, 1'b1, {8'h00, 1'b0, 1'b0, 1'b0, 8'h5A}},
    // walk the status bytes: match once the changed byte has been read
    '{OP_READ_BYTE,  8'h00, 8'h00, 8'h00, 1'b1, {8'h00, 1'b1, 1'b0, 1'b0, 8'h5A}},
    '{OP_READ_BYTE,  8'h00, 8'h00, 8'h00, 1'b1, {8'hA5, 1'b1, 1'b1, 1'b0, 8'h5A}},
    '{OP_READ_NACK,  8'h00, 8'h00, 8'h00, 1'b1, {8'h00, 1'b0, 1'b0, 1'b0, 8'h5A}},
    '{OP_LOCAL_WR,   8'h01, 8'h02, 8'h00, 1'b0, '0},
    '{OP_READ_BYTE,  8'h00, 8'h00, 8'h00, 1'b0, '0},
    '{OP_UNKNOWN,    8'h00, 8'h00, 8'h80, 1'b1, {8'h00, 1'b0, 1'b0, 1'b0, 8'h80}}
  };

  // Window settings per phase: reset values, the extremes, an empty write
  // window, a status window that wraps past 255, and a random last phase.
  logic [7:0] phase_windows [NumPhases-1][3] = '{
    '{8'd255, 8'd0,   8'd252},
    '{8'd0,   8'd255, 8'd0},
    '{8'd255, 8'd255, 8'd254},
    '{8'd10,  8'd20,  8'd5},
    '{8'd127, 8'd64,  8'd62},
    '{8'd200, 8'd100, 8'd198},
    '{8'd255, 8'd0,   8'd255}
  };

  initial begin : stimulus
    int unsigned phase_end;
    int unsigned pick;
    in_valid_i   = 1'b0;
    op_i         = OP_READ_BYTE;
    data_in_i    = 8'h00;
    local_addr_i = 8'h00;
    bus_code_i   = 8'h00;
    out_stall_i  = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = CfgLastReadable;
    cfg_data_i   = 8'h00;

    foreach (map_mem[i]) map_mem[i] = 8'h00;
    foreach (shadow_mem[i]) shadow_mem[i] = 8'h00;
    bus_ptr      = 8'h00;
    wr_flag      = 1'b0;
    busy_flag    = 1'b0;
    err_latched  = 8'h00;
    cfg_last_rd  = LastReadableReset;
    cfg_first_wr = FirstWritableReset;
    cfg_first_st = FirstStatusReset;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i])
      send_event(directed_rows[i].op, directed_rows[i].din, directed_rows[i].laddr,
                 directed_rows[i].code, directed_rows[i].typed, directed_rows[i].res);

    for (int p = 0; p < int'(NumPhases); p++) begin
      if (p != 0) begin
        settle();
        if (p == int'(NumPhases) - 1)
          write_windows(8'($urandom), 8'($urandom), 8'($urandom));
        else
          write_windows(phase_windows[p-1][0], phase_windows[p-1][1],
                        phase_windows[p-1][2]);
      end
      phase_end = events_sent + ItemsPerPhase;
      while (events_sent < phase_end) begin
        // every few dozen transactions, pick gappy or back-to-back per side
        if (events_sent % 48 < 4) begin
          src_gap_max = ($urandom_range(0, 3) == 0) ? 0 : MaxGap;
          snk_gap_max = ($urandom_range(0, 3) == 0) ? 0 : MaxGap;
        end
        pick = $urandom_range(0, 19);
        if (pick < 8) begin
          // master write: address, pointer byte, data bytes, stop
          send_event(OP_ADDR_WRITE, 8'($urandom), 8'($urandom), 8'($urandom));
          send_event(OP_DATA_RECV, pick_addr(), 8'($urandom), 8'($urandom));
          repeat ($urandom_range(0, 6))
            send_event(OP_DATA_RECV, pick_byte(), 8'($urandom), 8'($urandom));
          send_event(OP_STOP, 8'($urandom), 8'($urandom), 8'($urandom));
        end else if (pick < 15) begin
          // master read: usually set the pointer first, then restart and read
          if ($urandom_range(0, 3) != 0) begin
            send_event(OP_ADDR_WRITE, 8'($urandom), 8'($urandom), 8'($urandom));
            send_event(OP_DATA_RECV, pick_addr(), 8'($urandom), 8'($urandom));
            send_event(OP_STOP, 8'($urandom), 8'($urandom), 8'($urandom));
          end
          repeat ($urandom_range(1, 8))
            send_event(OP_READ_BYTE, 8'($urandom), 8'($urandom), 8'($urandom));
          send_event(OP_READ_NACK, 8'($urandom), 8'($urandom), 8'($urandom));
          send_event(OP_STOP, 8'($urandom), 8'($urandom), 8'($urandom));
        end else if (pick < 17) begin
          // device side updates a byte, often a status byte
          send_event(OP_LOCAL_WR, pick_byte(), pick_addr(), 8'($urandom));
        end else if (pick < 19) begin
          // lone event of any kind, unknown status included
          send_event(op_e'(3'($urandom_range(0, 7))), 8'($urandom), 8'($urandom),
                     8'($urandom));
        end else begin
          // transfer cut short by a bus error or an unknown status
          send_event(OP_ADDR_WRITE, 8'($urandom), 8'($urandom), 8'($urandom));
          send_event(OP_DATA_RECV, pick_addr(), 8'($urandom), 8'($urandom));
          send_event($urandom_range(0, 1) ? OP_ERROR : OP_UNKNOWN, pick_byte(),
                     8'($urandom), 8'($urandom));
          send_event(OP_STOP, 8'($urandom), 8'($urandom), 8'($urandom));
        end
      end
    end

    settle();
    repeat (TailCycles) @(posedge clk_i);
    if (n_mismatch == 0)
      $display("i2c_slave_register_file_core_tb: done, clean");
    else
      $display("i2c_slave_register_file_core_tb: done, errors");
    $finish;
  end

  // Timeout set well above the worst-case run length.
  initial begin : watchdog
    #5ms;
    $display("i2c_slave_register_file_core_tb: done, errors");
    $finish;
  end

endmodule
